@@ hw/rtl/vae_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator envelope package
// Shared constants, tables, codes and the token that walks the voice chain.
// ----------------------------------------------------------------------------
package vae_pkg;

  localparam int VOICE_COUNT     = 48;
  localparam int LEVEL_FRAC_BITS = 16;

  localparam int IDX_W   = $clog2(VOICE_COUNT);
  localparam int VOICE_W = 6;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int TIME_W  = 16;
  localparam int RATE_W  = 16;
  localparam int MODE_W  = 2;
  localparam int HZ_W    = 14;
  localparam int PEAK_W  = 13;
  localparam int NOTE_COUNT = 128;
  localparam int VEL_COUNT  = 128;

  // Level is fixed point; a level never exceeds the largest peak.
  localparam int LEVEL_W  = PEAK_W + LEVEL_FRAC_BITS;
  localparam int RAW_W    = 2 * RATE_W;
  localparam int UP_SHIFT = (LEVEL_FRAC_BITS >= 16) ? LEVEL_FRAC_BITS - 16 : 0;
  localparam int DN_SHIFT = (LEVEL_FRAC_BITS < 16) ? 16 - LEVEL_FRAC_BITS : 0;
  localparam int STEP_W   = RAW_W + UP_SHIFT;
  localparam int SUM_W    = ((LEVEL_W > STEP_W) ? LEVEL_W : STEP_W) + 1;

  // Steal candidates need a whole level below this bound.
  localparam int LIMIT_W     = 15;
  localparam int STEAL_LIMIT = 32767;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 2'd2;

  // Input kinds.
  localparam logic [MODE_W-1:0] MODE_ON   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ON,
    OP_OFF,
    OP_TICK,
    OP_STEAL
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_SCAN,
    ST_STEAL,
    ST_DONE
  } state_t;

  // Request travelling from cell to cell, one cell per cycle.
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic                  hold;
    logic [HZ_W-1:0]       hz;
    logic [PEAK_W-1:0]     peak;
    logic [STEP_W-1:0]     up;
    logic [STEP_W-1:0]     down;
    logic                  found;
    logic [IDX_W-1:0]      idx;
    logic                  best_valid;
    logic [PEAK_W-1:0]     best_whole;
    logic [IDX_W-1:0]      best_idx;
  } tok_t;

  typedef logic [HZ_W-1:0]   hz_rom_t   [NOTE_COUNT];
  typedef logic [PEAK_W-1:0] peak_rom_t [NOTE_COUNT];

  localparam hz_rom_t NOTE_HZ = '{
    14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12, 14'd12,
    14'd13, 14'd14, 14'd15, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19,
    14'd21, 14'd22, 14'd23, 14'd24, 14'd26, 14'd28, 14'd29, 14'd31,
    14'd33, 14'd35, 14'd37, 14'd39, 14'd41, 14'd44, 14'd46, 14'd49,
    14'd52, 14'd55, 14'd58, 14'd62, 14'd65, 14'd69, 14'd73, 14'd78,
    14'd82, 14'd87, 14'd92, 14'd98, 14'd104, 14'd110, 14'd117, 14'd123,
    14'd131, 14'd139, 14'd147, 14'd156, 14'd165, 14'd175, 14'd185, 14'd196,
    14'd208, 14'd220, 14'd233, 14'd247, 14'd262, 14'd277, 14'd294, 14'd311,
    14'd330, 14'd349, 14'd370, 14'd392, 14'd415, 14'd440, 14'd466, 14'd494,
    14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd740, 14'd784,
    14'd831, 14'd880, 14'd932, 14'd988, 14'd1047, 14'd1109, 14'd1175, 14'd1245,
    14'd1319, 14'd1397, 14'd1480, 14'd1568, 14'd1661, 14'd1760, 14'd1865, 14'd1976,
    14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2794, 14'd2960, 14'd3136,
    14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4435, 14'd4699, 14'd4978,
    14'd5274, 14'd5588, 14'd5920, 14'd6272, 14'd6645, 14'd7040, 14'd7459, 14'd7902,
    14'd8372, 14'd8870, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11840, 14'd12544
  };

  // Integer square root, evaluated only while building constant tables.
  function automatic int unsigned isqrt(int unsigned v);
    int unsigned r;
    int unsigned b;
    int unsigned x;
    r = 0;
    b = 32'h4000_0000;
    x = v;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Peak for a free voice: 60 times the square root of the note frequency.
  function automatic peak_rom_t build_note_peak();
    peak_rom_t t;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      t[n] = PEAK_W'(isqrt(3600 * int'(NOTE_HZ[n])));
    end
    return t;
  endfunction

  // Peak for a stolen voice: velocity scaled to 4096 at full scale of 100.
  function automatic peak_rom_t build_vel_peak();
    peak_rom_t t;
    for (int v = 0; v < VEL_COUNT; v++) begin
      t[v] = PEAK_W'((v * 4096) / 100);
    end
    return t;
  endfunction

  localparam peak_rom_t NOTE_PEAK = build_note_peak();
  localparam peak_rom_t VEL_PEAK  = build_vel_peak();

  // Rate times elapsed time, rescaled to the level's fraction bits.
  function automatic logic [STEP_W-1:0] scale_step(logic [RAW_W-1:0] raw);
    logic [STEP_W-1:0] s;
    s = STEP_W'(raw) << UP_SHIFT;
    return s >> DN_SHIFT;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/vae_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Voice cell
// Holds one voice and applies the passing request to it, then forwards it.
// ----------------------------------------------------------------------------
module vae_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [vae_pkg::IDX_W-1:0]  pos,
  input  wire vae_pkg::tok_t              tok_in,
  output vae_pkg::tok_t                   tok_out
);

  logic                            gate;
  logic                            gate_next;
  logic [vae_pkg::LEVEL_W-1:0]     level;
  logic [vae_pkg::LEVEL_W-1:0]     level_next;
  logic [vae_pkg::PEAK_W-1:0]      peak;
  logic [vae_pkg::PEAK_W-1:0]      peak_next;
  logic [vae_pkg::HZ_W-1:0]        hz;
  logic [vae_pkg::HZ_W-1:0]        hz_next;
  vae_pkg::tok_t                   tok_next;
  logic [vae_pkg::PEAK_W-1:0]      whole;
  logic [vae_pkg::SUM_W-1:0]       top;
  logic [vae_pkg::SUM_W-1:0]       sum;
  logic [vae_pkg::SUM_W-1:0]       lvl_wide;
  logic [vae_pkg::SUM_W-1:0]       down_wide;
  logic                            free;
  logic                            beats_best;

  always_comb begin
    whole      = level[vae_pkg::LEVEL_W-1 -: vae_pkg::PEAK_W];
    top        = vae_pkg::SUM_W'(peak) << vae_pkg::LEVEL_FRAC_BITS;
    lvl_wide   = vae_pkg::SUM_W'(level);
    down_wide  = vae_pkg::SUM_W'(tok_in.down);
    sum        = lvl_wide + vae_pkg::SUM_W'(tok_in.up);
    free       = !gate && (level == '0);
    beats_best = !gate
              && (vae_pkg::LIMIT_W'(whole) < vae_pkg::LIMIT_W'(vae_pkg::STEAL_LIMIT))
              && (!tok_in.best_valid || (whole < tok_in.best_whole));
  end

  always_comb begin
    tok_next   = tok_in;
    gate_next  = gate;
    level_next = level;
    peak_next  = peak;
    hz_next    = hz;
    if (tok_in.valid) begin
      unique case (tok_in.op)
        vae_pkg::OP_ON: begin
          if (free && !tok_in.found) begin
            gate_next      = 1'b1;
            peak_next      = tok_in.peak;
            hz_next        = tok_in.hz;
            tok_next.found = 1'b1;
            tok_next.idx   = pos;
          end
          if (beats_best) begin
            tok_next.best_valid = 1'b1;
            tok_next.best_whole = whole;
            tok_next.best_idx   = pos;
          end
        end
        vae_pkg::OP_OFF: begin
          if (gate && (hz == tok_in.hz) && !tok_in.found) begin
            gate_next      = 1'b0;
            tok_next.found = 1'b1;
            tok_next.idx   = pos;
          end
        end
        vae_pkg::OP_TICK: begin
          if (gate) begin
            if (sum > top) begin
              level_next = vae_pkg::LEVEL_W'(top);
              if (!tok_in.hold) begin
                gate_next = 1'b0;
              end
            end else begin
              level_next = vae_pkg::LEVEL_W'(sum);
            end
          end else if (down_wide >= lvl_wide) begin
            level_next = '0;
          end else begin
            level_next = vae_pkg::LEVEL_W'(lvl_wide - down_wide);
          end
        end
        vae_pkg::OP_STEAL: begin
          if (tok_in.idx == pos) begin
            gate_next = 1'b1;
            peak_next = tok_in.peak;
            hz_next   = tok_in.hz;
          end
        end
        vae_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate    <= 1'b0;
      level   <= '0;
      tok_out <= '0;
    end else begin
      gate    <= gate_next;
      level   <= level_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    peak <= peak_next;
    hz   <= hz_next;
  end

endmodule
`default_nettype wire

@@ hw/rtl/vae_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator control
// Takes transactions and configuration, launches requests into the voice
// chain, collects them at its end and presents the result.
// ----------------------------------------------------------------------------
module vae_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [31:0]                   s_tdata,
  input  wire logic [vae_pkg::MODE_W-1:0]    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [7:0]                         m_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [vae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vae_pkg::RATE_W-1:0]    cfg_wdata,
  output vae_pkg::tok_t                      launch,
  input  wire vae_pkg::tok_t                 ret
);

  vae_pkg::state_t                 state;
  vae_pkg::state_t                 state_next;
  logic [vae_pkg::RATE_W-1:0]      attack;
  logic [vae_pkg::RATE_W-1:0]      release_rate;
  logic                            hold;
  vae_pkg::op_t                    op_q;
  logic [vae_pkg::HZ_W-1:0]        hz_q;
  logic [vae_pkg::PEAK_W-1:0]      peak_note_q;
  logic [vae_pkg::PEAK_W-1:0]      peak_vel_q;
  logic [vae_pkg::TIME_W-1:0]      elapsed_q;
  logic [vae_pkg::NOTE_W-1:0]      in_note;
  logic [vae_pkg::VEL_W-1:0]       in_vel;
  logic [vae_pkg::TIME_W-1:0]      in_elapsed;
  vae_pkg::op_t                    in_op;
  logic [vae_pkg::RAW_W-1:0]       raw_up;
  logic [vae_pkg::RAW_W-1:0]       raw_dn;
  logic                            steal_needed;
  logic                            out_free;
  logic                            fire_scan;
  logic                            fire_steal;
  logic                            capture_res;
  logic                            load_out;
  logic                            res_found_c;
  logic                            res_stolen_c;
  logic [vae_pkg::IDX_W-1:0]       res_idx_c;
  logic                            res_found;
  logic                            res_stolen;
  logic [vae_pkg::VOICE_W-1:0]     res_voice;

  assign in_note    = s_tdata[6:0];
  assign in_vel     = s_tdata[13:7];
  assign in_elapsed = s_tdata[29:14];

  // A note on with zero velocity is handled as a note off.
  always_comb begin
    unique case (s_tuser)
      vae_pkg::MODE_ON:   in_op = (in_vel == '0) ? vae_pkg::OP_OFF : vae_pkg::OP_ON;
      vae_pkg::MODE_OFF:  in_op = vae_pkg::OP_OFF;
      vae_pkg::MODE_TICK: in_op = vae_pkg::OP_TICK;
      default:            in_op = vae_pkg::OP_NONE;
    endcase
  end

  assign raw_up = vae_pkg::RAW_W'(attack) * vae_pkg::RAW_W'(elapsed_q);
  assign raw_dn = vae_pkg::RAW_W'(release_rate) * vae_pkg::RAW_W'(elapsed_q);

  assign steal_needed = (op_q == vae_pkg::OP_ON) && !ret.found && ret.best_valid;
  assign out_free     = !m_tvalid || m_tready;

  always_comb begin
    res_found_c  = ((op_q == vae_pkg::OP_ON) || (op_q == vae_pkg::OP_OFF))
                && (ret.found || steal_needed);
    res_stolen_c = steal_needed;
    res_idx_c    = ret.found ? ret.idx : (steal_needed ? ret.best_idx : '0);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      vae_pkg::ST_IDLE:  if (s_tvalid) state_next = vae_pkg::ST_RATE;
      vae_pkg::ST_RATE:  state_next = vae_pkg::ST_SCAN;
      vae_pkg::ST_SCAN: begin
        if (ret.valid) begin
          state_next = steal_needed ? vae_pkg::ST_STEAL : vae_pkg::ST_DONE;
        end
      end
      vae_pkg::ST_STEAL: if (ret.valid) state_next = vae_pkg::ST_DONE;
      vae_pkg::ST_DONE:  if (out_free) state_next = vae_pkg::ST_IDLE;
      default:           state_next = vae_pkg::ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    s_tready    = (state == vae_pkg::ST_IDLE);
    fire_scan   = (state == vae_pkg::ST_RATE);
    capture_res = (state == vae_pkg::ST_SCAN) && ret.valid;
    fire_steal  = capture_res && steal_needed;
    load_out    = (state == vae_pkg::ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vae_pkg::ST_IDLE;
      attack       <= '0;
      release_rate <= '0;
      hold         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          vae_pkg::REG_ATTACK:  attack       <= cfg_wdata;
          vae_pkg::REG_RELEASE: release_rate <= cfg_wdata;
          vae_pkg::REG_HOLD:    hold         <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    launch.valid <= !rst && (fire_scan || fire_steal);
    if (s_tvalid && s_tready) begin
      op_q        <= in_op;
      hz_q        <= vae_pkg::NOTE_HZ[in_note];
      peak_note_q <= vae_pkg::NOTE_PEAK[in_note];
      peak_vel_q  <= vae_pkg::VEL_PEAK[in_vel];
      elapsed_q   <= in_elapsed;
    end
    if (fire_scan) begin
      launch.op         <= op_q;
      launch.hold       <= hold;
      launch.hz         <= hz_q;
      launch.peak       <= peak_note_q;
      launch.up         <= vae_pkg::scale_step(raw_up);
      launch.down       <= vae_pkg::scale_step(raw_dn);
      launch.found      <= 1'b0;
      launch.idx        <= '0;
      launch.best_valid <= 1'b0;
      launch.best_whole <= '0;
      launch.best_idx   <= '0;
    end else if (fire_steal) begin
      launch.op    <= vae_pkg::OP_STEAL;
      launch.peak  <= peak_vel_q;
      launch.idx   <= ret.best_idx;
      launch.found <= 1'b0;
    end
    if (capture_res) begin
      res_found  <= res_found_c;
      res_stolen <= res_stolen_c;
      res_voice  <= res_found_c ? vae_pkg::VOICE_W'(res_idx_c) : '0;
    end
    if (load_out) begin
      m_tdata <= {res_stolen, res_found, res_voice};
    end
  end

  // Requests only come back while one is outstanding.
  a_ret_when_busy: assert property (@(posedge clk) disable iff (rst)
    ret.valid |-> (state == vae_pkg::ST_SCAN || state == vae_pkg::ST_STEAL))
    else $error("voice chain returned a request while none was outstanding");

  // A steal pass follows only a note on that found no free voice.
  a_steal_cause: assert property (@(posedge clk) disable iff (rst)
    fire_steal |-> (op_q == vae_pkg::OP_ON && !ret.found && ret.best_valid))
    else $error("steal pass launched without a steal candidate");

  // A stolen voice is always a found voice.
  a_stolen_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[7] || m_tdata[6]))
    else $error("stolen flag set without found");

  // Without a voice the reported index is zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[6]) |-> (m_tdata[5:0] == '0))
    else $error("nonzero voice reported with found clear");

  // A launch goes out only for one cycle at a time.
  a_launch_pulse: assert property (@(posedge clk) disable iff (rst)
    launch.valid |=> !launch.valid)
    else $error("launch held for more than one cycle");

endmodule
`default_nettype wire

@@ hw/rtl/voice_allocator_envelope_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Voice allocator with envelope, top level
// A bank of synthesizer voices held one per cell along a chain. Each
// transaction is note on, note off or a time tick, and yields one result.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one event per transaction; s_tuser holds the
//   kind (0 note on, 1 note off, 2 tick) and s_tdata the note, velocity and
//   elapsed time. The master stream returns one result per event: the voice
//   that was allocated or released, a found flag and a stolen flag.
//   Configuration (attack rate, release rate, hold at peak) is written on
//   the cfg port while no event is in flight.
//   Each event walks the whole chain, one voice cell per cycle, before its
//   result is registered. A note on that finds no free voice walks the chain
//   a second time to start the stolen voice. One event is in flight at a time.
//   s_tready is high while the block waits for an event. A finished result
//   moves into the output register and the next event is accepted while it
//   waits there; if the receiver stalls longer, the block holds the next
//   result and stops taking events until the output register frees up.
//   Reset clears all gates and levels, the configuration and both streams.
// ----------------------------------------------------------------------------
module voice_allocator_envelope_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // note [6:0], velocity [13:7], elapsed [29:14], zero [31:30]
  input  wire logic [31:0]                   s_tdata,
  // mode [1:0]
  input  wire logic [vae_pkg::MODE_W-1:0]    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // voice [5:0], found [6], stolen [7]
  output logic [7:0]                         m_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [vae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vae_pkg::RATE_W-1:0]    cfg_wdata
);

  // Request path: control launches into cell 0, the last cell hands back.
  vae_pkg::tok_t chain [vae_pkg::VOICE_COUNT+1];

  vae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .launch    (chain[0]),
    .ret       (chain[vae_pkg::VOICE_COUNT])
  );

  // Cell k holds voice k; its position is what a match reports.
  for (genvar k = 0; k < vae_pkg::VOICE_COUNT; k++) begin : g_cell
    vae_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .pos     (vae_pkg::IDX_W'(k)),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

endmodule
`default_nettype wire
